// ----- design/vlpg_pkg.sv -----
// vlpg_pkg: shared constants and types for the vector line point generator
// depends on nothing; imported by the top level, the divider and the checker

package vlpg_pkg;

    localparam int COUNT_BITS_DEF = 14;
    localparam int COORD_W        = 16;
    localparam int SLOPE_W        = 16;
    localparam int OCT_W          = 3;

    // function codes of an input transaction
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // octant codes: which axis takes the index and which signs apply
    localparam logic [OCT_W-1:0] OCT_XOFF_YPI  = 3'd0;
    localparam logic [OCT_W-1:0] OCT_XPI_YOFF  = 3'd1;
    localparam logic [OCT_W-1:0] OCT_XPI_YMOFF = 3'd2;
    localparam logic [OCT_W-1:0] OCT_XOFF_YMI  = 3'd3;
    localparam logic [OCT_W-1:0] OCT_XMOFF_YMI = 3'd4;
    localparam logic [OCT_W-1:0] OCT_XMI_YMOFF = 3'd5;
    localparam logic [OCT_W-1:0] OCT_XMI_YOFF  = 3'd6;
    localparam logic [OCT_W-1:0] OCT_XMOFF_YPI = 3'd7;

    // handshake between the sequencer and the divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- design/vlpg_div.sv -----
// vlpg_div: iterative restoring divider, one quotient bit per cycle
// depends on vlpg_pkg (control and status structs)

module vlpg_div #(
    parameter int DIVIDEND_W = 30,
    parameter int DIVISOR_W  = 14
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  vlpg_pkg::div_ctrl_t      ctrl,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0]     divisor,
    output vlpg_pkg::div_stat_t      stat,
    output logic [DIVIDEND_W-1:0]    quotient
);
    import vlpg_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // shift next dividend bit into the partial remainder and try a subtract
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- design/vector_line_point_generator_top.sv -----
// vector_line_point_generator_top: line point generator with serial divider
// depends on vlpg_pkg and vlpg_div
//
// usage
//   input channel (in_valid / in_ready) carries one command per transaction.
//   func load latches start point, point count, slope and octant and gives
//   no result; in_ready stays high after it. func step asks for the next
//   point of the active line and gives one result transaction on the
//   output channel (out_valid / out_ready); a step with no active line is
//   dropped with no result. the step giving the last point clears the line.
// timing
//   the accepting edge loads slope * index into the restoring divider,
//   which gives one quotient bit per cycle over 16 + COUNT_BITS bits; the
//   sequencer then sees it finish and writes the output register, raising
//   out_valid. in_ready is low all that time, so a new step is accepted
//   only after the last one is written to the output register.
// stall and reset
//   the result sits in the output register until taken; a new command may
//   be accepted meanwhile, and a finished step waits for the register to
//   drain before writing. reset drops any line and any pending result.

module vector_line_point_generator_top #(
    parameter int COUNT_BITS = vlpg_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [vlpg_pkg::COORD_W-1:0]  start_x,
    input  logic [vlpg_pkg::COORD_W-1:0]  start_y,
    input  logic [COUNT_BITS-1:0]         point_count,
    input  logic [vlpg_pkg::SLOPE_W-1:0]  slope,
    input  logic [vlpg_pkg::OCT_W-1:0]    direction,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vlpg_pkg::COORD_W-1:0]  pixel_x,
    output logic [vlpg_pkg::COORD_W-1:0]  pixel_y,
    output logic                          last_point
);
    import vlpg_pkg::*;

    // width of slope * index, the dividend of the divider
    localparam int PROD_W = SLOPE_W + COUNT_BITS;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]            state_reg, state_next;

    // latched line command
    logic [COORD_W-1:0]    origin_x_reg, origin_x_next;
    logic [COORD_W-1:0]    origin_y_reg, origin_y_next;
    logic [COUNT_BITS-1:0] length_reg, length_next;
    logic [SLOPE_W-1:0]    slope_reg, slope_next;
    logic [OCT_W-1:0]      octant_reg, octant_next;
    logic [COUNT_BITS-1:0] index_reg, index_next;
    logic                  active_reg, active_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]    px_reg, px_next;
    logic [COORD_W-1:0]    py_reg, py_next;
    logic                  last_reg, last_next;

    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     quotient;

    logic                  in_fire;
    logic [16:0]           rounded;
    logic [COORD_W-1:0]    off;
    logic [COORD_W-1:0]    maj;
    logic                  is_last;
    logic                  out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // single multiplier between registers, result goes straight into the divider
    assign product = PROD_W'(slope_reg) * PROD_W'(index_reg);

    assign div_ctrl.start = in_fire && (func == FUNC_STEP) && active_reg;

    vlpg_div #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (product),
        .divisor  (length_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // round the quotient to half, zero count gives no offset at all
    assign rounded = quotient[16:0] + 17'd1;
    assign off     = (length_reg == '0) ? '0 : rounded[16:1];
    assign maj     = COORD_W'(index_reg);
    assign is_last = (index_reg >= length_reg);

    always_comb
    begin
        state_next     = state_reg;
        origin_x_next  = origin_x_reg;
        origin_y_next  = origin_y_reg;
        length_next    = length_reg;
        slope_next     = slope_reg;
        octant_next    = octant_reg;
        index_next     = index_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !out_ready;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        // a load abandons any line in progress
                        origin_x_next = start_x;
                        origin_y_next = start_y;
                        length_next   = point_count;
                        slope_next    = slope;
                        octant_next   = direction;
                        index_next    = '0;
                        active_next   = 1'b1;
                    end
                    else if (active_reg)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = is_last;
                    case (octant_reg)
                        OCT_XOFF_YPI:
                        begin
                            px_next = origin_x_reg + off;
                            py_next = origin_y_reg + maj;
                        end
                        OCT_XPI_YOFF:
                        begin
                            px_next = origin_x_reg + maj;
                            py_next = origin_y_reg + off;
                        end
                        OCT_XPI_YMOFF:
                        begin
                            px_next = origin_x_reg + maj;
                            py_next = origin_y_reg - off;
                        end
                        OCT_XOFF_YMI:
                        begin
                            px_next = origin_x_reg + off;
                            py_next = origin_y_reg - maj;
                        end
                        OCT_XMOFF_YMI:
                        begin
                            px_next = origin_x_reg - off;
                            py_next = origin_y_reg - maj;
                        end
                        OCT_XMI_YMOFF:
                        begin
                            px_next = origin_x_reg - maj;
                            py_next = origin_y_reg - off;
                        end
                        OCT_XMI_YOFF:
                        begin
                            px_next = origin_x_reg - maj;
                            py_next = origin_y_reg + off;
                        end
                        default:
                        begin
                            px_next = origin_x_reg - off;
                            py_next = origin_y_reg + maj;
                        end
                    endcase
                    // advance the index, or close the line on its final point
                    if (is_last)
                    begin
                        active_next = 1'b0;
                        index_next  = '0;
                    end
                    else
                    begin
                        index_next = index_reg + COUNT_BITS'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            length_reg    <= '0;
            slope_reg     <= '0;
            octant_reg    <= '0;
            index_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            origin_x_reg  <= origin_x_next;
            origin_y_reg  <= origin_y_next;
            length_reg    <= length_next;
            slope_reg     <= slope_next;
            octant_reg    <= octant_next;
            index_reg     <= index_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, qualified by out_valid_reg
    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_point = last_reg;

endmodule

// ----- design/vlpg_checker.sv -----
// vlpg_checker: port-level assertions for the line point generator
// depends on vlpg_pkg; bound to vector_line_point_generator_top below

module vlpg_checker #(
    parameter int COUNT_BITS = vlpg_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          func,
    input  logic [COUNT_BITS-1:0]         point_count,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [vlpg_pkg::COORD_W-1:0]  pixel_x,
    input  logic [vlpg_pkg::COORD_W-1:0]  pixel_y,
    input  logic                          last_point
);
    import vlpg_pkg::*;

    logic out_stall;
    logic load_fire;

    assign out_stall = out_valid && !out_ready;
    assign load_fire = in_valid && in_ready && (func == FUNC_LOAD);

    // a stalled result stays offered
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_stall_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> ($stable(pixel_x) && $stable(pixel_y) && $stable(last_point)))
        else $error("result payload changed while stalled");

    // a new result only follows a busy period of the sequencer
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a step in progress");

    // a load transaction never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> !$rose(out_valid))
        else $error("load transaction produced a result");

    // a load with a zero count still leaves the generator ready afterwards
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && (point_count == '0)) |=> in_ready)
        else $error("generator busy after a load");

endmodule

bind vector_line_point_generator_top vlpg_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_vlpg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .point_count (point_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last_point  (last_point)
);
